/* rtl/me_pkg.sv */
package me_pkg;

   // Configuration register indexes.
   localparam logic [0:0] CSR_MODULUS  = 1'b0;
   localparam logic [0:0] CSR_EXPONENT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MULT,
      ST_DONE
   } state_type;

endpackage

/* rtl/me_reduce.sv */
module me_reduce import me_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] remainder
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] shift_ff, shift_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;

   // Restoring division: one dividend bit enters the partial remainder per cycle.
   assign trial = {rem_ff, shift_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, modulus};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         shift_in = dividend;
      end else if (busy_ff) begin
         rem_in   = (trial >= {1'b0, modulus}) ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         shift_in = {shift_ff[WIDTH-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/me_mulmod.sv */
module me_mulmod import me_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] mcand,
   input  logic [WIDTH-1:0] mplier,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             phase_ff, phase_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] mplier_ff, mplier_in;
   logic [WIDTH-1:0] addend;
   logic [WIDTH:0]   sum;
   logic [WIDTH:0]   diff;
   logic [WIDTH-1:0] sum_mod;

   // Each multiplier bit, MSB first, is handled as a doubling followed by a
   // conditional add of the multiplicand. Both share one modular adder.
   assign addend  = phase_ff ? mcand : acc_ff;
   assign sum     = {1'b0, acc_ff} + {1'b0, addend};
   assign diff    = sum - {1'b0, modulus};
   assign sum_mod = (sum >= {1'b0, modulus}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      phase_in  = phase_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         phase_in  = 1'b0;
         count_in  = '0;
         acc_in    = '0;
         mplier_in = mplier;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            acc_in   = sum_mod;
            phase_in = 1'b1;
         end else begin
            if (mplier_ff[WIDTH-1]) begin
               acc_in = sum_mod;
            end
            mplier_in = {mplier_ff[WIDTH-2:0], 1'b0};
            phase_in  = 1'b0;
            count_in  = count_ff + 1'b1;
            if (count_ff == CW'(WIDTH - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* rtl/modular_exponentiation.sv */
// Modular exponentiation: rsp_power_result = req_base_value ^ exponent mod modulus.
// Configuration: write modulus (index 0) and exponent (index 1) through the csr_
// channel while no request is in flight. csr_ready is always high. A write of zero
// to the modulus is ignored. After reset the modulus and the exponent are both 1.
// Requests: a request is taken when req_valid is high and req_stall is low. One
// request is worked on at a time; req_stall stays high until its result has been
// moved into the output register.
// Operation: a bit-serial divider first reduces the base. Each exponent bit up to
// the most significant set bit then takes a square and a multiply, which run side
// by side in two shift-and-add units that handle one multiplier bit at a time.
// The result then goes through ST_DONE into the output register and rsp_valid. A
// zero exponent skips the square and the multiply. A new request is not taken
// before the previous result has been moved into the output register.
// Results: rsp_valid holds the result until rsp_stall is low. While the receiver
// stalls, the next request can be taken and computed; it waits in the last step
// until the output register frees.
// Reset is synchronous and active high; it drops any request in flight.
module modular_exponentiation import me_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WIDTH-1:0] req_base_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [WIDTH-1:0] rsp_power_result,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [0:0]       csr_index,
   input  logic [WIDTH-1:0] csr_data
);

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic [WIDTH-1:0] exponent_ff, exponent_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             red_start;
   logic             mul_start;
   logic             out_load;
   logic             red_done;
   logic [WIDTH-1:0] red_rem;
   logic             sq_done;
   logic [WIDTH-1:0] sq_product;
   logic             mp_done;
   logic [WIDTH-1:0] mp_product;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   me_reduce #(.WIDTH(WIDTH)) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .dividend  (req_base_value),
      .modulus   (modulus_ff),
      .done      (red_done),
      .remainder (red_rem)
   );

   me_mulmod #(.WIDTH(WIDTH)) u_square (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (base_ff),
      .mplier  (base_ff),
      .modulus (modulus_ff),
      .done    (sq_done),
      .product (sq_product)
   );

   me_mulmod #(.WIDTH(WIDTH)) u_multiply (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (res_ff),
      .mplier  (base_ff),
      .modulus (modulus_ff),
      .done    (mp_done),
      .product (mp_product)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (red_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (exp_ff == '0) ? ST_DONE : ST_MULT;
         end
         ST_MULT: begin
            if (sq_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs.
   always_comb begin
      req_stall = 1'b1;
      red_start = 1'b0;
      mul_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            red_start = req_valid;
         end
         ST_CHECK: begin
            mul_start = (exp_ff != '0);
         end
         ST_DONE: begin
            out_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Datapath and configuration.
   always_comb begin
      modulus_in   = modulus_ff;
      exponent_in  = exponent_ff;
      exp_in       = exp_ff;
      base_in      = base_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODULUS: begin
               if (csr_data != '0) begin
                  modulus_in = csr_data;
               end
            end
            CSR_EXPONENT: begin
               exponent_in = csr_data;
            end
            default: begin
               modulus_in = modulus_ff;
            end
         endcase
      end

      if (accept) begin
         exp_in = exponent_ff;
         res_in = WIDTH'(1);
      end
      if (red_done) begin
         base_in = red_rem;
      end
      // Both units finish together; the multiply result is kept only for a set bit.
      if (state_ff == ST_MULT && sq_done) begin
         base_in = sq_product;
         if (exp_ff[0] && mp_done) begin
            res_in = mp_product;
         end
         exp_in = exp_ff >> 1;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= WIDTH'(1);
         exponent_ff  <= WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff      <= exp_in;
      base_ff     <= base_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

endmodule
